// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the Michael digest RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/mmd_pkg.sv
// ----------------------------------------------------------------------------
// mmd_pkg
// Types, codes and the block round shared by the Michael digest modules.
// ----------------------------------------------------------------------------
package mmd_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_RIGHT = 2'd1;

  localparam logic [7:0] PAD_BYTE = 8'h5a;

  // round phases within one command
  localparam logic [1:0] PH_WORD = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_ZERO = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } mmd_in_t;

  typedef struct packed {
    logic [31:0] tag_left;
    logic [31:0] tag_right;
  } mmd_out_t;

  // one unit of work for the back end
  typedef struct packed {
    logic        load_key;
    logic [31:0] key_left;
    logic [31:0] key_right;
    logic        has_word;
    logic [31:0] word;
    logic        is_final;
    logic [31:0] pad;
  } mmd_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] swap_pairs(input logic [31:0] v);
    swap_pairs = ((v & 32'h00ff00ff) << 8) | ((v & 32'hff00ff00) >> 8);
  endfunction

  // returns {left, right}
  function automatic logic [63:0] block_round(input logic [31:0] l_in,
                                              input logic [31:0] r_in);
    logic [31:0] l;
    logic [31:0] r;
    l = l_in;
    r = r_in;
    r = r ^ rotl(l, 17);
    l = l + r;
    r = r ^ swap_pairs(l);
    l = l + r;
    r = r ^ rotl(l, 3);
    l = l + r;
    r = r ^ rotl(l, 30);
    l = l + r;
    block_round = {l, r};
  endfunction

endpackage

// File: rtl/mmd_fifo.sv
// ----------------------------------------------------------------------------
// mmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmd_fifo
  import mmd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  mmd_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output mmd_cmd_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mmd_cmd_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o)
  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > FULL_CNT)

endmodule

// File: rtl/mmd_front.sv
// ----------------------------------------------------------------------------
// mmd_front
// Takes byte words, gathers bytes into 32-bit words and issues round commands.
// ----------------------------------------------------------------------------
module mmd_front
  import mmd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  mmd_in_t              in_data_i,
  output logic                 in_stall_o,
  input  logic                 q_full_i,
  output logic                 push_o,
  output mmd_cmd_t             push_data_o
);

  logic [31:0] key_l_q, key_r_q;
  logic [31:0] snap_l_q, snap_r_q;
  logic        fresh_q;
  logic        load_pend_q, load_pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [23:0] pw_q, pw_d;

  logic        accept;
  logic        active;
  logic        full_word;
  logic [1:0]  cnt_cur;
  logic [23:0] pw_cur;
  logic        load_now;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign active     = accept && (in_data_i.has_byte || in_data_i.end_of_message);
  assign cnt_cur    = fresh_q ? 2'd0 : cnt_q;
  assign pw_cur     = fresh_q ? 24'd0 : pw_q;
  assign full_word  = in_data_i.has_byte && (cnt_cur == 2'd3);
  assign load_now   = fresh_q || load_pend_q;
  assign push_o     = active && (full_word || in_data_i.end_of_message);

  always_comb begin
    cnt_d = cnt_cur;
    pw_d  = pw_cur;
    if (in_data_i.has_byte) begin
      if (full_word) begin
        cnt_d = 2'd0;
        pw_d  = '0;
      end else begin
        cnt_d = cnt_cur + 2'd1;
        pw_d  = pw_cur | (24'(in_data_i.data_byte) << {cnt_cur, 3'b000});
      end
    end
  end

  always_comb begin
    load_pend_d = load_pend_q;
    if (push_o) begin
      load_pend_d = 1'b0;
    end else if (active) begin
      load_pend_d = load_now;
    end
  end

  always_comb begin
    push_data_o.load_key  = load_now;
    push_data_o.key_left  = fresh_q ? key_l_q : snap_l_q;
    push_data_o.key_right = fresh_q ? key_r_q : snap_r_q;
    push_data_o.has_word  = full_word;
    push_data_o.word      = {in_data_i.data_byte, pw_cur};
    push_data_o.is_final  = in_data_i.end_of_message;
    push_data_o.pad       = {8'h00, pw_d} | (32'(PAD_BYTE) << {cnt_d, 3'b000});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_l_q     <= '0;
      key_r_q     <= '0;
      fresh_q     <= 1'b1;
      load_pend_q <= 1'b0;
      cnt_q       <= '0;
      pw_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_KEY_LEFT:  key_l_q <= cfg_data_i;
          CFG_KEY_RIGHT: key_r_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (active) begin
        load_pend_q <= in_data_i.end_of_message ? 1'b0 : load_pend_d;
        fresh_q     <= in_data_i.end_of_message;
        cnt_q       <= in_data_i.end_of_message ? 2'd0 : cnt_d;
        pw_q        <= in_data_i.end_of_message ? 24'd0 : pw_d;
      end
    end
  end

  // key as seen at the first item of the message
  always_ff @(posedge clk_i) begin
    if (active && fresh_q) begin
      snap_l_q <= key_l_q;
      snap_r_q <= key_r_q;
    end
  end

endmodule

// File: rtl/mmd_back.sv
// ----------------------------------------------------------------------------
// mmd_back
// Runs Michael block rounds, one per cycle unless stalled; holds the tag word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmd_back
  import mmd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  mmd_cmd_t cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  output mmd_out_t out_data_o,
  input  logic     out_stall_i
);

  logic [31:0] l_q, r_q;
  logic [1:0]  step_q, step_d;
  logic        out_valid_q;
  mmd_out_t    out_q;

  logic [1:0]  phase;
  logic        last;
  logic        emit;
  logic        out_free;
  logic        go;
  logic        first;
  logic [31:0] base_l, base_r, mix;
  logic [63:0] rnd;

  assign phase    = step_q + (cmd_i.has_word ? 2'd0 : 2'd1);
  assign last     = cmd_i.is_final ? (phase == PH_ZERO) : 1'b1;
  assign emit     = cmd_i.is_final && last;
  assign out_free = !out_valid_q || !out_stall_i;
  assign go       = cmd_valid_i && (!emit || out_free);
  assign first    = (step_q == 2'd0) && cmd_i.load_key;
  assign base_l   = first ? cmd_i.key_left : l_q;
  assign base_r   = first ? cmd_i.key_right : r_q;
  assign pop_o    = go && last;

  always_comb begin
    case (phase)
      PH_WORD: mix = cmd_i.word;
      PH_PAD:  mix = cmd_i.pad;
      default: mix = '0;
    endcase
  end

  assign rnd    = block_round(base_l ^ mix, base_r);
  assign step_d = pop_o ? 2'd0 : step_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go) begin
        step_q <= step_d;
      end
      if (go && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      l_q <= rnd[63:32];
      r_q <= rnd[31:0];
    end
    if (go && emit) begin
      out_q.tag_left  <= rnd[63:32];
      out_q.tag_right <= rnd[31:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLIES(a_mid_cmd_held, clk_i, rst_ni, step_q != 2'd0, cmd_valid_i)
  `ASSERT_NEVER(a_step_range, clk_i, rst_ni, step_q == 2'd3)
  `ASSERT_IMPLIES(a_emit_on_final, clk_i, rst_ni, go && emit, cmd_i.is_final)

endmodule

// File: rtl/michael_mic_digest.sv
// Throughput: one item per cycle while the command queue is not full; the round unit runs a
// word round per full word and a pad and a zero round per message end, and a QUEUE_DEPTH-entry
// command queue absorbs bursts of short messages.
// Reset: asynchronous, active low; keys clear to zero, queue empties, next item starts a message.
// ----------------------------------------------------------------------------
// michael_mic_digest
// Keyed Michael MIC over a byte stream, with decoupled gather and round stages.
// ----------------------------------------------------------------------------
module michael_mic_digest
  import mmd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  mmd_in_t              in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output mmd_out_t             out_data_o,
  input  logic                 out_stall_i
);

  logic     q_full;
  logic     q_push;
  mmd_cmd_t q_push_data;
  logic     q_pop;
  logic     q_valid;
  mmd_cmd_t q_head;

  assign cfg_ready_o = 1'b1;

  mmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  mmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  mmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: test/michael_mic_digest_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// michael_mic_digest_tb
// Self-checking bench for the Michael digest: a table of directed messages,
// then random messages under several keys and idling patterns, each tag
// compared with a local model of the Michael rounds.
// ----------------------------------------------------------------------------
module michael_mic_digest_tb;
  import mmd_pkg::*;

  typedef struct packed {
    mmd_in_t  word;
    logic     typed;
    mmd_out_t tag;
  } dir_row_t;

  localparam int unsigned ROWS = 21;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_KEY_LEFT;
  logic [31:0]          cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  mmd_in_t              in_data_i = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  mmd_out_t             out_data_o;
  logic                 out_stall_i = 1'b0;

  // model state
  logic [31:0] key_l = '0;
  logic [31:0] key_r = '0;
  logic [31:0] half_l = '0;
  logic [31:0] half_r = '0;
  logic [23:0] part_word = '0;
  logic [1:0]  part_cnt = '0;
  bit          fresh = 1'b1;

  mmd_out_t    tags_due[$];
  bit          failed = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned words_sent = 0;

  // empty message under the all-zero key is a published vector
  dir_row_t directed_rows [ROWS] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{32'h1c5c9282, 32'hb830d1a1}},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'ha5, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h5a, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b0, 1'b1}, 1'b0, '0},
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h02, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h03, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b0, '0},
    '{'{8'hff, 1'b0, 1'b1}, 1'b0, '0},
    '{'{8'h80, 1'b1, 1'b1}, 1'b0, '0}
  };

  michael_mic_digest i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("michael_mic_digest: mismatch");
    $finish;
  end

  function automatic void michael_round(inout logic [31:0] l, inout logic [31:0] r);
    r = r ^ {l[14:0], l[31:15]};
    l = l + r;
    r = r ^ {l[23:16], l[31:24], l[7:0], l[15:8]};
    l = l + r;
    r = r ^ {l[28:0], l[31:29]};
    l = l + r;
    r = r ^ {l[1:0], l[31:2]};
    l = l + r;
  endfunction

  // advance the digest by one accepted word; queue the tag at message end
  function automatic void absorb_byte(input mmd_in_t w);
    logic [31:0] padded;
    if (!w.has_byte && !w.end_of_message) return;
    if (fresh) begin
      half_l    = key_l;
      half_r    = key_r;
      part_word = '0;
      part_cnt  = '0;
      fresh     = 1'b0;
    end
    if (w.has_byte) begin
      if (part_cnt == 2'd3) begin
        half_l = half_l ^ {w.data_byte, part_word};
        michael_round(half_l, half_r);
        part_word = '0;
        part_cnt  = '0;
      end else begin
        part_word[8*part_cnt +: 8] = w.data_byte;
        part_cnt = part_cnt + 2'd1;
      end
    end
    if (w.end_of_message) begin
      padded = {8'h00, part_word};
      padded[8*part_cnt +: 8] = PAD_BYTE;
      half_l = half_l ^ padded;
      michael_round(half_l, half_r);
      michael_round(half_l, half_r);
      tags_due.push_back('{tag_left: half_l, tag_right: half_r});
      part_word = '0;
      part_cnt  = '0;
      fresh     = 1'b1;
    end
  endfunction

  // called and returns at a falling edge; valid is left high for the caller
  task automatic send_byte(input mmd_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    absorb_byte(w);
    if (w.has_byte || w.end_of_message) words_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_keys(input logic [31:0] left, input logic [31:0] right);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_KEY_LEFT;
    cfg_data_i  <= left;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_l = left;
    @(negedge clk_i);
    cfg_index_i <= CFG_KEY_RIGHT;
    cfg_data_i  <= right;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_r = right;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // bytes of a message, with stray idle words mixed in; optionally closed
  task automatic send_message(input int unsigned len, input bit close);
    mmd_in_t w;
    bit      merged;
    merged = close && len != 0 && $urandom_range(1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_byte('{8'($urandom_range(255)), 1'b0, 1'b0});
      w = '{8'($urandom_range(255)), 1'b1, 1'b0};
      if (merged && i == len - 1) w.end_of_message = 1'b1;
      send_byte(w);
    end
    if (close && !merged) send_byte('{8'($urandom_range(255)), 1'b0, 1'b1});
  endtask

  task automatic settle;
    in_valid_i <= 1'b0;
    while (tags_due.size() != 0) @(negedge clk_i);
    // word rounds may still be queued with no tag behind them
    repeat (16) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin : tag_check
    mmd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tags_due.size() == 0) begin
        $display("%0t: tag with none due: %h", $time, out_data_o);
        failed = 1'b1;
      end else begin
        want = tags_due.pop_front();
        if (out_data_o.tag_left !== want.tag_left) begin
          $display("%0t: tag_left expected %h actual %h", $time, want.tag_left,
                   out_data_o.tag_left);
          failed = 1'b1;
        end
        if (out_data_o.tag_right !== want.tag_right) begin
          $display("%0t: tag_right expected %h actual %h", $time, want.tag_right,
                   out_data_o.tag_right);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned len;
    logic [31:0] kl;
    logic [31:0] kr;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table under the reset key
    for (int unsigned i = 0; i < ROWS; i++) begin
      send_byte(directed_rows[i].word);
      if (directed_rows[i].typed) tags_due[$] = directed_rows[i].tag;
    end
    settle();

    for (int unsigned ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      case (ph)
        0: begin kl = '1; kr = '1; end
        1: begin kl = '0; kr = '0; end
        2: begin kl = '1; kr = '0; end
        3: begin kl = '0; kr = '1; end
        default: begin kl = $urandom; kr = $urandom; end
      endcase
      // an open message from the last phase carries on under its old key
      write_keys(kl, kr);
      words_sent = 0;
      while (words_sent < 100) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(11);
        send_message(len, 1'b1);
      end
      send_message($urandom_range(5), 1'b0);
      settle();
    end
    send_message(0, 1'b1);
    settle();
    stall_pct = 0;

    if (!failed) begin
      $display("michael_mic_digest: match");
    end else begin
      $display("michael_mic_digest: mismatch");
    end
    $finish;
  end

endmodule
